/* src/chhic_pkg.sv */
`default_nettype none

package chhic_pkg;

    // Angle accumulator: 2^-20 degree units, signed, covers -100..+280 degrees
    localparam int ANG_SCALE_BITS = 20;
    localparam int ZW             = 31;
    localparam int TABLE_LEN      = 24;

    localparam logic signed [ZW-1:0] HALF_TURN_Z = ZW'(180 << ANG_SCALE_BITS);
    localparam logic signed [ZW-1:0] FULL_TURN_Z = ZW'(360 << ANG_SCALE_BITS);

    // Register indexes of the configuration port
    typedef enum logic [1:0] {
        REG_MODE     = 2'd0,
        REG_X_OFFSET = 2'd1,
        REG_Y_OFFSET = 2'd2
    } cfg_reg_t;

    // Side information that travels with each item down the chain
    typedef struct packed {
        logic               force_zero;
        logic signed [15:0] fx;
        logic signed [15:0] fy;
        logic signed [15:0] fz;
    } side_t;

    // atan(2^-i) in 2^-20 degree units, rounded to nearest
    function automatic logic signed [ZW-1:0] atan_step(input int idx);
        logic signed [ZW-1:0] v;
        case (idx)
            0:  v = ZW'(47185920);
            1:  v = ZW'(27855475);
            2:  v = ZW'(14718068);
            3:  v = ZW'(7471121);
            4:  v = ZW'(3750058);
            5:  v = ZW'(1876857);
            6:  v = ZW'(938658);
            7:  v = ZW'(469357);
            8:  v = ZW'(234682);
            9:  v = ZW'(117342);
            10: v = ZW'(58671);
            11: v = ZW'(29335);
            12: v = ZW'(14668);
            13: v = ZW'(7334);
            14: v = ZW'(3667);
            15: v = ZW'(1833);
            16: v = ZW'(917);
            17: v = ZW'(458);
            18: v = ZW'(229);
            19: v = ZW'(115);
            20: v = ZW'(57);
            21: v = ZW'(29);
            22: v = ZW'(14);
            23: v = ZW'(7);
            default: v = '0;
        endcase
        return v;
    endfunction

endpackage

`default_nettype wire

/* src/chhic_prep.sv */
`default_nettype none

module chhic_prep
    import chhic_pkg::*;
(
    input  wire                aclk,
    input  wire                aresetn,
    input  wire                cfg_wr_en,
    input  wire  [1:0]         cfg_index,
    input  wire  [15:0]        cfg_wdata,
    input  wire                in_valid,
    output logic               in_ready,
    input  wire  signed [15:0] mag_x,
    input  wire  signed [15:0] mag_y,
    input  wire  signed [15:0] mag_z,
    output logic               out_valid,
    input  wire                out_ready,
    output logic signed [16:0] a_o,
    output logic signed [16:0] b_o,
    output logic               neg_o,
    output side_t              side_o
);

    logic               mode_reg;
    logic signed [15:0] xoff_reg;
    logic signed [15:0] yoff_reg;
    logic signed [15:0] lo_reg [0:2];
    logic signed [15:0] hi_reg [0:2];
    logic signed [15:0] lo_next [0:2];
    logic signed [15:0] hi_next [0:2];
    logic signed [15:0] mid [0:2];
    logic signed [15:0] sample [0:2];
    logic signed [16:0] sum [0:2];
    logic signed [16:0] sum_adj [0:2];

    logic               valid_reg;
    logic signed [16:0] a_reg;
    logic signed [16:0] b_reg;
    logic               neg_reg;
    side_t              side_reg;

    logic signed [16:0] dx;
    logic signed [16:0] dy;
    logic               accept;

    assign in_ready = !valid_reg || out_ready;
    assign accept   = in_valid && in_ready;

    assign sample[0] = mag_x;
    assign sample[1] = mag_y;
    assign sample[2] = mag_z;

    // Track extremes with this sample, then take midpoints truncated toward zero
    always_comb begin
        for (int k = 0; k < 3; k++) begin
            lo_next[k] = lo_reg[k];
            hi_next[k] = hi_reg[k];
            if (mode_reg && (sample[k] < lo_reg[k])) begin
                lo_next[k] = sample[k];
            end
            if (mode_reg && (sample[k] > hi_reg[k])) begin
                hi_next[k] = sample[k];
            end
            sum[k]     = {lo_next[k][15], lo_next[k]} + {hi_next[k][15], hi_next[k]};
            sum_adj[k] = sum[k] + {16'd0, sum[k][16]};
            mid[k]     = sum_adj[k][16:1];
        end
    end

    // Remove hard-iron offset and fold into the right half plane
    assign dx = {mag_x[15], mag_x} - {xoff_reg[15], xoff_reg};
    assign dy = {mag_y[15], mag_y} - {yoff_reg[15], yoff_reg};

    // Configuration, trackers and stage valid
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg  <= 1'b0;
            xoff_reg  <= '0;
            yoff_reg  <= '0;
            valid_reg <= 1'b0;
            for (int k = 0; k < 3; k++) begin
                lo_reg[k] <= 16'sh7FFF;
                hi_reg[k] <= 16'sh8000;
            end
        end else begin
            if (in_ready) begin
                valid_reg <= in_valid;
            end
            if (cfg_wr_en) begin
                case (cfg_index)
                    REG_MODE: begin
                        mode_reg <= cfg_wdata[0];
                        if (cfg_wdata[0]) begin
                            for (int k = 0; k < 3; k++) begin
                                lo_reg[k] <= 16'sh7FFF;
                                hi_reg[k] <= 16'sh8000;
                            end
                        end
                    end
                    REG_X_OFFSET: xoff_reg <= cfg_wdata;
                    REG_Y_OFFSET: yoff_reg <= cfg_wdata;
                    default: ;
                endcase
            end else if (accept) begin
                for (int k = 0; k < 3; k++) begin
                    lo_reg[k] <= lo_next[k];
                    hi_reg[k] <= hi_next[k];
                end
            end
        end
    end

    // Capture payload on transfer
    always_ff @(posedge aclk) begin
        if (accept) begin
            neg_reg             <= dy[16];
            a_reg               <= dy[16] ? -dx : dx;
            b_reg               <= dy[16] ? -dy : dy;
            side_reg.force_zero <= mode_reg || ((dx == '0) && (dy == '0));
            side_reg.fx         <= mid[0];
            side_reg.fy         <= mid[1];
            side_reg.fz         <= mid[2];
        end
    end

    assign out_valid = valid_reg;
    assign a_o       = a_reg;
    assign b_o       = b_reg;
    assign neg_o     = neg_reg;
    assign side_o    = side_reg;

endmodule

`default_nettype wire

/* src/chhic_cell.sv */
`default_nettype none

module chhic_cell
    import chhic_pkg::*;
#(
    parameter int W    = 36,
    parameter int STEP = 0
) (
    input  wire                   aclk,
    input  wire                   aresetn,
    input  wire                   in_valid,
    output logic                  in_ready,
    input  wire  signed [W-1:0]   a_i,
    input  wire  signed [W-1:0]   b_i,
    input  wire  signed [ZW-1:0]  z_i,
    input  side_t                 side_i,
    output logic                  out_valid,
    input  wire                   out_ready,
    output logic signed [W-1:0]   a_o,
    output logic signed [W-1:0]   b_o,
    output logic signed [ZW-1:0]  z_o,
    output side_t                 side_o
);

    localparam logic signed [ZW-1:0] STEP_ANGLE = atan_step(STEP);

    logic                  valid_reg;
    logic signed [W-1:0]   a_reg;
    logic signed [W-1:0]   b_reg;
    logic signed [ZW-1:0]  z_reg;
    side_t                 side_reg;
    logic signed [W-1:0]   a_sh;
    logic signed [W-1:0]   b_sh;
    logic                  rot_up;

    assign in_ready = !valid_reg || out_ready;

    // One vectoring micro-rotation, floor shifts
    assign a_sh   = a_i >>> STEP;
    assign b_sh   = b_i >>> STEP;
    assign rot_up = a_i[W-1];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (in_ready) begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_valid && in_ready) begin
            a_reg    <= rot_up ? a_i + b_sh : a_i - b_sh;
            b_reg    <= rot_up ? b_i - a_sh : b_i + a_sh;
            z_reg    <= rot_up ? z_i - STEP_ANGLE : z_i + STEP_ANGLE;
            side_reg <= side_i;
        end
    end

    assign out_valid = valid_reg;
    assign a_o       = a_reg;
    assign b_o       = b_reg;
    assign z_o       = z_reg;
    assign side_o    = side_reg;

endmodule

`default_nettype wire

/* src/chhic_finish.sv */
`default_nettype none

module chhic_finish
    import chhic_pkg::*;
#(
    parameter int FRACTION_BITS = 6
) (
    input  wire                   aclk,
    input  wire                   aresetn,
    input  wire                   in_valid,
    output logic                  in_ready,
    input  wire  signed [ZW-1:0]  z_i,
    input  side_t                 side_i,
    output logic                  out_valid,
    input  wire                   out_ready,
    output logic        [14:0]    heading,
    output logic signed [15:0]    found_x_offset,
    output logic signed [15:0]    found_y_offset,
    output logic signed [15:0]    found_z_offset
);

    localparam int ROUND_SHIFT = ANG_SCALE_BITS - FRACTION_BITS;
    localparam logic signed [ZW-1:0] HALF_LSB   = ZW'(1) <<< (ROUND_SHIFT - 1);
    localparam logic signed [ZW-1:0] WRAP_LIMIT = ZW'(360 << FRACTION_BITS);

    logic                  valid_reg;
    logic        [14:0]    heading_reg;
    side_t                 side_reg;
    logic signed [ZW-1:0]  z_wrap;
    logic signed [ZW-1:0]  z_round;
    logic signed [ZW-1:0]  r_raw;
    logic signed [ZW-1:0]  r_wrap;

    assign in_ready = !valid_reg || out_ready;

    // Wrap into one turn, round half up, fold a full turn back to zero
    always_comb begin
        z_wrap  = z_i[ZW-1] ? z_i + FULL_TURN_Z : z_i;
        z_round = z_wrap + HALF_LSB;
        r_raw   = z_round >>> ROUND_SHIFT;
        r_wrap  = (r_raw >= WRAP_LIMIT) ? r_raw - WRAP_LIMIT : r_raw;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (in_ready) begin
            valid_reg <= in_valid;
        end
    end

    // Hold result until the downstream transfer
    always_ff @(posedge aclk) begin
        if (in_valid && in_ready) begin
            heading_reg <= side_i.force_zero ? 15'd0 : r_wrap[14:0];
            side_reg    <= side_i;
        end
    end

    assign out_valid      = valid_reg;
    assign heading        = heading_reg;
    assign found_x_offset = side_reg.fx;
    assign found_y_offset = side_reg.fy;
    assign found_z_offset = side_reg.fz;

endmodule

`default_nettype wire

/* src/compass_heading_with_hard_iron_cal_core.sv */
`default_nettype none

// Compass heading with hard-iron calibration.
// Input channel s_*: one signed magnetometer sample (x, y, z) per transfer.
// Result channel m_*: heading in 2^-FRACTION_BITS degree units plus the
// midpoints of the per-axis min/max trackers as found hard-iron offsets.
// Configuration: cfg_wr_en/cfg_index/cfg_wdata write mode (0 heading,
// 1 calibrate; writing 1 clears the trackers), x_offset and y_offset.
// Write configuration only while no item is in flight.
// Pipeline from input transfer to m_valid: one offset/fold stage, one
// cell per CORDIC micro-rotation, one rounding stage, all registered.
// Throughput: one item per cycle while m_ready is high; every stage sets this.
// When the receiver stalls, each stage holds its item and ready backs up
// only as far as the chain is full, so bubbles are squeezed out.
// Reset: mode heading, offsets zero, trackers cleared, all stages empty.
// In calibrate mode the heading field is zero.

module compass_heading_with_hard_iron_cal_core
    import chhic_pkg::*;
#(
    parameter int ANGLE_STEPS   = 16,
    parameter int FRACTION_BITS = 6
) (
    input  wire                aclk,
    input  wire                aresetn,
    input  wire                cfg_wr_en,
    input  wire  [1:0]         cfg_index,
    input  wire  [15:0]        cfg_wdata,
    input  wire                s_valid,
    output logic               s_ready,
    input  wire  signed [15:0] s_mag_x,
    input  wire  signed [15:0] s_mag_y,
    input  wire  signed [15:0] s_mag_z,
    output logic               m_valid,
    input  wire                m_ready,
    output logic        [14:0] m_heading,
    output logic signed [15:0] m_found_x_offset,
    output logic signed [15:0] m_found_y_offset,
    output logic signed [15:0] m_found_z_offset
);

    // Datapath width: 17-bit input, 2^ANGLE_STEPS scale, CORDIC gain headroom
    localparam int W     = ANGLE_STEPS + 20;
    localparam int GUARD = W - 17 - ANGLE_STEPS;

    logic                  vld [0:ANGLE_STEPS];
    logic                  rdy [0:ANGLE_STEPS];
    logic signed [W-1:0]   a_q [0:ANGLE_STEPS];
    logic signed [W-1:0]   b_q [0:ANGLE_STEPS];
    logic signed [ZW-1:0]  z_q [0:ANGLE_STEPS];
    side_t                 side_q [0:ANGLE_STEPS];

    logic signed [16:0]    a_prep;
    logic signed [16:0]    b_prep;
    logic                  neg_prep;

    chhic_prep u_prep (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .in_valid  (s_valid),
        .in_ready  (s_ready),
        .mag_x     (s_mag_x),
        .mag_y     (s_mag_y),
        .mag_z     (s_mag_z),
        .out_valid (vld[0]),
        .out_ready (rdy[0]),
        .a_o       (a_prep),
        .b_o       (b_prep),
        .neg_o     (neg_prep),
        .side_o    (side_q[0])
    );

    // Scale into the rotation width and seed the base angle
    assign a_q[0] = $signed({{GUARD{a_prep[16]}}, a_prep, {ANGLE_STEPS{1'b0}}});
    assign b_q[0] = $signed({{GUARD{b_prep[16]}}, b_prep, {ANGLE_STEPS{1'b0}}});
    assign z_q[0] = neg_prep ? HALF_TURN_Z : '0;

    for (genvar i = 0; i < ANGLE_STEPS; i++) begin : g_cell
        chhic_cell #(
            .W    (W),
            .STEP (i)
        ) u_cell (
            .aclk      (aclk),
            .aresetn   (aresetn),
            .in_valid  (vld[i]),
            .in_ready  (rdy[i]),
            .a_i       (a_q[i]),
            .b_i       (b_q[i]),
            .z_i       (z_q[i]),
            .side_i    (side_q[i]),
            .out_valid (vld[i+1]),
            .out_ready (rdy[i+1]),
            .a_o       (a_q[i+1]),
            .b_o       (b_q[i+1]),
            .z_o       (z_q[i+1]),
            .side_o    (side_q[i+1])
        );
    end

    chhic_finish #(
        .FRACTION_BITS (FRACTION_BITS)
    ) u_finish (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .in_valid       (vld[ANGLE_STEPS]),
        .in_ready       (rdy[ANGLE_STEPS]),
        .z_i            (z_q[ANGLE_STEPS]),
        .side_i         (side_q[ANGLE_STEPS]),
        .out_valid      (m_valid),
        .out_ready      (m_ready),
        .heading        (m_heading),
        .found_x_offset (m_found_x_offset),
        .found_y_offset (m_found_y_offset),
        .found_z_offset (m_found_z_offset)
    );

endmodule

`default_nettype wire

/* src/chhic_checker.sv */
`default_nettype none

module chhic_checker
    import chhic_pkg::*;
#(
    parameter int FRACTION_BITS = 6
) (
    input wire        aclk,
    input wire        aresetn,
    input wire        cfg_wr_en,
    input wire [1:0]  cfg_index,
    input wire [15:0] cfg_wdata,
    input wire        s_ready,
    input wire        m_valid,
    input wire        m_ready,
    input wire [14:0] m_heading,
    input wire [15:0] m_found_x_offset
);

    logic mode_reg;

    // Follow the mode register from the configuration port
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg <= 1'b0;
        end else if (cfg_wr_en && (cfg_index == REG_MODE)) begin
            mode_reg <= cfg_wdata[0];
        end
    end

    // Reset empties the chain and leaves the input open
    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !m_valid && s_ready)
        else $error("chain not empty after reset");

    // A stalled result holds
    a_stall_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_heading)
                                && $stable(m_found_x_offset))
        else $error("stalled result changed");

    // Calibrate mode gives a zero heading
    a_cal_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && mode_reg |-> m_heading == 15'd0)
        else $error("heading not zero in calibrate mode");

    // Heading stays below a full turn
    a_heading_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (int'(m_heading) < (360 << FRACTION_BITS)))
        else $error("heading out of range");

endmodule

bind compass_heading_with_hard_iron_cal_core chhic_checker #(
    .FRACTION_BITS (FRACTION_BITS)
) u_chhic_checker (
    .aclk             (aclk),
    .aresetn          (aresetn),
    .cfg_wr_en        (cfg_wr_en),
    .cfg_index        (cfg_index),
    .cfg_wdata        (cfg_wdata),
    .s_ready          (s_ready),
    .m_valid          (m_valid),
    .m_ready          (m_ready),
    .m_heading        (m_heading),
    .m_found_x_offset (m_found_x_offset)
);

`default_nettype wire

/* verif/compass_heading_with_hard_iron_cal_core_tb.sv */
module compass_heading_with_hard_iron_cal_core_tb
    import chhic_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    localparam int     ANGLE_STEPS   = 16;
    localparam int     FRACTION_BITS = 6;
    localparam int     CLK_PERIOD    = 10;
    localparam int     CYCLE_LIMIT   = 400_000;
    localparam int     PIPE_DEPTH    = ANGLE_STEPS + 2;
    localparam int     MAX_REPORTS   = 50;
    localparam longint HALF_TURN_Q20 = longint'(180) <<< 20;
    localparam longint FULL_TURN_Q20 = longint'(360) <<< 20;
    localparam longint FULL_TURN_OUT = longint'(360) <<< FRACTION_BITS;

    // Index with no register behind it; writes to it must be ignored
    localparam logic [1:0] SPARE_REG = 2'd3;

    typedef struct {
        logic signed [15:0] x;
        logic signed [15:0] y;
        logic signed [15:0] z;
    } mag_sample_t;

    typedef struct {
        logic        [14:0] heading;
        logic signed [15:0] fx;
        logic signed [15:0] fy;
        logic signed [15:0] fz;
    } compass_result_t;

    // DUT connections
    logic               aclk      = 1'b0;
    logic               aresetn   = 1'b0;
    logic               cfg_wr_en = 1'b0;
    logic [1:0]         cfg_index = REG_MODE;
    logic [15:0]        cfg_wdata = '0;
    logic               s_valid   = 1'b0;
    logic               s_ready;
    logic signed [15:0] s_mag_x   = '0;
    logic signed [15:0] s_mag_y   = '0;
    logic signed [15:0] s_mag_z   = '0;
    logic               m_valid;
    logic               m_ready   = 1'b0;
    logic        [14:0] m_heading;
    logic signed [15:0] m_found_x_offset;
    logic signed [15:0] m_found_y_offset;
    logic signed [15:0] m_found_z_offset;

    // Predicted register and tracker state
    logic               cal_mode = 1'b0;
    logic signed [15:0] off_x    = '0;
    logic signed [15:0] off_y    = '0;
    logic signed [15:0] lo_x     = 16'sh7FFF;
    logic signed [15:0] lo_y     = 16'sh7FFF;
    logic signed [15:0] lo_z     = 16'sh7FFF;
    logic signed [15:0] hi_x     = 16'sh8000;
    logic signed [15:0] hi_y     = 16'sh8000;
    logic signed [15:0] hi_z     = 16'sh8000;

    // atan(2^-i) in 2^-20 degree
    longint atan_q20 [0:23] = '{
        47185920, 27855475, 14718068, 7471121, 3750058, 1876857, 938658, 469357,
        234682, 117342, 58671, 29335, 14668, 7334, 3667, 1833,
        917, 458, 229, 115, 57, 29, 14, 7
    };

    mag_sample_t     sample_q [$];
    compass_result_t expected_results [$];
    mag_sample_t     next_sample;

    int send_idle_pct   = 0;
    int recv_idle_pct   = 0;
    int pending_count   = 0;
    int error_count     = 0;
    int results_checked = 0;
    int calib_items     = 0;
    int heading_items   = 0;
    int zero_vectors    = 0;
    int reg_writes      = 0;
    int cycle_count     = 0;

    compass_heading_with_hard_iron_cal_core #(
        .ANGLE_STEPS   (ANGLE_STEPS),
        .FRACTION_BITS (FRACTION_BITS)
    ) uut (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .cfg_wr_en        (cfg_wr_en),
        .cfg_index        (cfg_index),
        .cfg_wdata        (cfg_wdata),
        .s_valid          (s_valid),
        .s_ready          (s_ready),
        .s_mag_x          (s_mag_x),
        .s_mag_y          (s_mag_y),
        .s_mag_z          (s_mag_z),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_heading        (m_heading),
        .m_found_x_offset (m_found_x_offset),
        .m_found_y_offset (m_found_y_offset),
        .m_found_z_offset (m_found_z_offset)
    );

    always #(CLK_PERIOD / 2) aclk = ~aclk;

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
    end

    // Vectoring CORDIC on (north, east), folded to the right half plane first
    function automatic logic [14:0] cordic_heading(input longint east, input longint north);
        longint a, b, z, t, da, db, r;
        a = east;
        b = north;
        z = 0;
        if (a == 0 && b == 0) begin
            return '0;
        end
        if (b < 0) begin
            a = -a;
            b = -b;
            z = HALF_TURN_Q20;
        end
        a = a <<< ANGLE_STEPS;
        b = b <<< ANGLE_STEPS;
        for (int i = 0; i < ANGLE_STEPS && i < 24; i++) begin
            da = a >>> i;
            db = b >>> i;
            if (a < 0) begin
                t = b - da;
                a = a + db;
                b = t;
                z = z - atan_q20[i];
            end else begin
                t = b + da;
                a = a - db;
                b = t;
                z = z + atan_q20[i];
            end
        end
        if (z < 0) z = z + FULL_TURN_Q20;
        if (z >= FULL_TURN_Q20) z = z - FULL_TURN_Q20;
        // Round half up to the output resolution; a full turn reads as zero
        r = ((z <<< FRACTION_BITS) + (longint'(1) <<< 19)) >>> 20;
        if (r >= FULL_TURN_OUT) r = r - FULL_TURN_OUT;
        return r[14:0];
    endfunction

    // Midpoint of a tracker, truncated toward zero
    function automatic logic signed [15:0] tracker_mid(input logic signed [15:0] lo,
                                                       input logic signed [15:0] hi);
        int m;
        m = (int'(lo) + int'(hi)) / 2;
        return m[15:0];
    endfunction

    // Update trackers or compute heading for one accepted sample
    function automatic void record_expected(input logic signed [15:0] mx,
                                            input logic signed [15:0] my,
                                            input logic signed [15:0] mz);
        compass_result_t res;
        longint east, north;
        res.heading = '0;
        if (cal_mode) begin
            if (mx < lo_x) lo_x = mx;
            if (my < lo_y) lo_y = my;
            if (mz < lo_z) lo_z = mz;
            if (mx > hi_x) hi_x = mx;
            if (my > hi_y) hi_y = my;
            if (mz > hi_z) hi_z = mz;
            calib_items++;
        end else begin
            east  = longint'(mx) - longint'(off_x);
            north = longint'(my) - longint'(off_y);
            if (east == 0 && north == 0) zero_vectors++;
            res.heading = cordic_heading(east, north);
            heading_items++;
        end
        res.fx = tracker_mid(lo_x, hi_x);
        res.fy = tracker_mid(lo_y, hi_y);
        res.fz = tracker_mid(lo_z, hi_z);
        expected_results.push_back(res);
    endfunction

    task automatic flag_mismatch(input string msg);
        error_count++;
        if (error_count <= MAX_REPORTS) begin
            $display("[%0t] mismatch: %s", $realtime, msg);
        end
    endtask

    // Write one register through the configuration port and track it
    task automatic write_reg(input logic [1:0] idx, input logic [15:0] val);
        @(posedge aclk);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val;
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        reg_writes++;
        case (idx)
            REG_MODE: begin
                cal_mode = val[0];
                if (val[0]) begin
                    lo_x = 16'sh7FFF; lo_y = 16'sh7FFF; lo_z = 16'sh7FFF;
                    hi_x = 16'sh8000; hi_y = 16'sh8000; hi_z = 16'sh8000;
                end
            end
            REG_X_OFFSET: off_x = val;
            REG_Y_OFFSET: off_y = val;
            default: ;
        endcase
    endtask

    task automatic push_sample(input logic signed [15:0] x, input logic signed [15:0] y,
                               input logic signed [15:0] z);
        mag_sample_t s;
        s.x = x;
        s.y = y;
        s.z = z;
        sample_q.push_back(s);
        pending_count++;
    endtask

    // Hold until every queued sample has come back as a result
    task automatic drain();
        wait (pending_count == 0);
    endtask

    function automatic logic signed [15:0] near(input logic signed [15:0] centre,
                                                input int spread);
        int v;
        v = int'(centre) + int'($urandom_range(2 * spread)) - spread;
        return v[15:0];
    endfunction

    // Axis value biased toward the offset so that small vectors turn up often
    function automatic logic signed [15:0] pick_axis(input logic signed [15:0] centre);
        logic signed [15:0] v;
        case ($urandom_range(9))
            0, 1, 2, 3: v = 16'($urandom);
            4, 5, 6:    v = near(centre, 300);
            7:          v = centre;
            8:          v = $urandom_range(1) ? 16'sh7FFF : 16'sh8000;
            default:    v = near(centre, 4);
        endcase
        return v;
    endfunction

    // Sender: predict on transfer, then present the next sample or idle
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else begin
            if (s_valid && s_ready) begin
                record_expected(s_mag_x, s_mag_y, s_mag_z);
            end
            if (!s_valid || s_ready) begin
                if (sample_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
                    next_sample = sample_q.pop_front();
                    s_valid <= 1'b1;
                    s_mag_x <= next_sample.x;
                    s_mag_y <= next_sample.y;
                    s_mag_z <= next_sample.z;
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    // Receiver: random back-pressure and field-by-field comparison
    always @(posedge aclk) begin
        m_ready <= ($urandom_range(99) >= recv_idle_pct);
        if (aresetn && m_valid && m_ready) begin
            if (expected_results.size() == 0) begin
                flag_mismatch($sformatf("result with nothing outstanding, heading %0d",
                                        m_heading));
            end else begin
                if (m_heading !== expected_results[0].heading)
                    flag_mismatch($sformatf("heading %0d, predicted %0d",
                                            m_heading, expected_results[0].heading));
                if (m_found_x_offset !== expected_results[0].fx)
                    flag_mismatch($sformatf("found_x_offset %0d, predicted %0d",
                                            m_found_x_offset, expected_results[0].fx));
                if (m_found_y_offset !== expected_results[0].fy)
                    flag_mismatch($sformatf("found_y_offset %0d, predicted %0d",
                                            m_found_y_offset, expected_results[0].fy));
                if (m_found_z_offset !== expected_results[0].fz)
                    flag_mismatch($sformatf("found_z_offset %0d, predicted %0d",
                                            m_found_z_offset, expected_results[0].fz));
                void'(expected_results.pop_front());
                results_checked++;
                pending_count--;
            end
        end
    end

    initial begin
        wait (cycle_count >= CYCLE_LIMIT);
        $display("timed out after %0d cycles", cycle_count);
        $display("FAILURE");
        $finish;
    end

    initial begin
        logic signed [15:0] cx, cy, cz;
        int spread;
        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;

        send_idle_pct = 34;
        recv_idle_pct = 87;

        // Heading at reset offsets: zero vector, axes, extremes, wrap near 360
        push_sample(0, 0, 0);
        push_sample(16'sh7FFF, 0, 16'sh7FFF);
        push_sample(16'sh8000, 0, 16'sh8000);
        push_sample(0, 16'sh7FFF, 0);
        push_sample(0, 16'sh8000, 0);
        push_sample(16'sh8000, 16'sh8000, 1);
        push_sample(16'sh7FFF, 16'sh7FFF, -1);
        push_sample(-1, 16'sh7FFF, 0);
        push_sample(1, -1, 0);
        drain();

        // Extreme offsets: widest difference vectors and a zero vector
        write_reg(REG_X_OFFSET, 16'h8000);
        write_reg(REG_Y_OFFSET, 16'h7FFF);
        push_sample(16'sh7FFF, 16'sh8000, 0);
        push_sample(16'sh8000, 16'sh7FFF, 0);
        push_sample(16'sh8000, 16'sh8000, 5);
        drain();

        // Calibrate on the extremes, then clear and read empty trackers
        write_reg(REG_MODE, 16'd1);
        push_sample(16'sh8000, 16'sh7FFF, 16'sh8000);
        push_sample(16'sh7FFF, 16'sh8000, 16'sh7FFF);
        push_sample(100, -100, 7);
        drain();
        write_reg(REG_MODE, 16'd1);
        write_reg(REG_MODE, 16'hFFFE);
        push_sample(5, 5, 5);
        drain();

        // A write to the spare index must leave every register alone
        write_reg(SPARE_REG, 16'hFFFF);
        push_sample(3, 4, -3);
        drain();

        // Leaving calibrate mode keeps the trackers
        write_reg(REG_MODE, 16'd1);
        push_sample(12, -7, 300);
        drain();
        write_reg(REG_MODE, 16'd0);
        push_sample(12, -7, 300);
        drain();

        for (int p = 0; p < 3; p++) begin
            case (p)
                0: begin send_idle_pct = 34; recv_idle_pct = 87; end
                1: begin send_idle_pct = 87; recv_idle_pct = 34; end
                default: begin send_idle_pct = 0; recv_idle_pct = 0; end
            endcase

            // Calibration sweep around a random hard-iron centre
            write_reg(REG_MODE, 16'd1);
            cx = near(0, 4000);
            cy = near(0, 4000);
            cz = near(0, 4000);
            spread = $urandom_range(3000, 50);
            for (int i = 0; i < 150; i++) begin
                if ($urandom_range(19) == 0)
                    push_sample(16'($urandom), 16'($urandom), 16'($urandom));
                else
                    push_sample(near(cx, spread), near(cy, spread), near(cz, spread));
            end
            drain();

            // Load offsets: found ones, extremes, then arbitrary values
            case (p)
                0: begin
                    write_reg(REG_X_OFFSET, tracker_mid(lo_x, hi_x));
                    write_reg(REG_Y_OFFSET, tracker_mid(lo_y, hi_y));
                end
                1: begin
                    write_reg(REG_X_OFFSET, 16'h7FFF);
                    write_reg(REG_Y_OFFSET, 16'h8000);
                end
                default: begin
                    write_reg(REG_X_OFFSET, 16'($urandom));
                    write_reg(REG_Y_OFFSET, 16'($urandom));
                end
            endcase
            write_reg(REG_MODE, {15'($urandom), 1'b0});

            // Heading run, with the sender held until the pipe empties halfway
            for (int i = 0; i < 480; i++) begin
                if (i == 240) drain();
                if ($urandom_range(24) == 0)
                    push_sample(off_x, off_y, 16'($urandom));
                else
                    push_sample(pick_axis(off_x), pick_axis(off_y), pick_axis(0));
            end
            drain();
        end

        repeat (PIPE_DEPTH + 20) @(posedge aclk);
        if (expected_results.size() != 0)
            flag_mismatch($sformatf("%0d results never arrived", expected_results.size()));

        $display("Run covered %0d samples: %0d calibrating, %0d heading (%0d zero vectors)",
                 calib_items + heading_items, calib_items, heading_items, zero_vectors);
        $display("Checked %0d results across %0d register writes and three pacing phases",
                 results_checked, reg_writes);
        if (error_count == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule
